// ===== rtl/core/rrts_pkg.sv =====
// Package for the round-robin thread scheduler: sizes, codes and item types.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
package rrts_pkg;
  localparam int MaxThreads = 32;
  localparam int NumQueues  = 8;
  localparam int NumSignals = 32;
  localparam int TidW = $clog2(MaxThreads);
  localparam int PtrW = TidW + 1;
  localparam int QW   = $clog2(NumQueues);
  localparam int SigW = $clog2(NumSignals);
  localparam logic [PtrW-1:0] Nil = PtrW'(MaxThreads);

  typedef enum logic [2:0] {
    FN_YIELD = 3'd0, FN_CREATE = 3'd1, FN_SLEEP = 3'd2, FN_WAKE1 = 3'd3,
    FN_WAKEALL = 3'd4, FN_SIGNAL = 3'd5, FN_EXIT = 3'd6, FN_NOP = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_DEAD = 2'd0, ST_READY = 2'd1, ST_RUN = 2'd2, ST_BLOCK = 2'd3
  } tstate_e;

  typedef enum logic [1:0] {
    STS_OK = 2'd0, STS_STALL = 2'd1, STS_BADARG = 2'd2, STS_EXHAUST = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WALL, S_UNLINK, S_FIN
  } fsm_e;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] queue_id;
    logic [4:0] target_thread;
    logic [4:0] signal_number;
  } req_t;

  typedef struct packed {
    logic [4:0] running_thread;
    logic       running_valid;
    logic       switched;
    logic [4:0] created_thread;
    logic [1:0] status;
  } rsp_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic wall_step;
    logic unlink_step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_wall;
    logic need_unlink;
    logic walk_done;
  } sts_t;
endpackage

// ===== rtl/core/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
`timescale 1ns / 1ps
// Usage: drive req_i and raise start; the item is taken at a clock edge where
// start is high and busy is low. busy then stays high until the result
// is shown. Each item yields exactly one result, presented on rsp_o for one
// cycle with done_o high; the receiver cannot hold it off and must take it.
// Simple events pass through the execute and finish states before done_o rises.
// Wake all adds a walk state that moves one waiter per cycle and then sees the
// end of the list. Signal unlink follows one list link per cycle from the queue
// head to the target's predecessor.
// Items are handled one at a time: busy is already low in the cycle done_o
// is high, so the next item can be accepted at the edge that ends that cycle.
// Reset: thread 0 runs, all other threads are dead, all queues are empty, and
// the next identifier handed out by create is 1. The thread tables sit in
// flip-flops, so reset clears them at once and no sweep is needed.
// The list walk is bounded by the thread count, so a corrupt list cannot hang.
module round_robin_thread_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  rrts_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output rrts_pkg::rsp_t rsp_o
);
  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  // Controller sequences execute, list walk and finish steps.
  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Datapath holds all thread state and the result register.
  rrts_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result shown twice");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item not in progress");
endmodule

// ===== rtl/core/rrts_ctrl.sv =====
// Controller state machine of the thread scheduler.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rrts_pkg::sts_t sts_i,
  output rrts_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  rrts_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rrts_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::S_IDLE: if (start_i) state_d = rrts_pkg::S_EXEC;
      rrts_pkg::S_EXEC: begin
        if (sts_i.need_wall) state_d = rrts_pkg::S_WALL;
        else if (sts_i.need_unlink) state_d = rrts_pkg::S_UNLINK;
        else state_d = rrts_pkg::S_FIN;
      end
      rrts_pkg::S_WALL: if (sts_i.walk_done) state_d = rrts_pkg::S_FIN;
      rrts_pkg::S_UNLINK: if (sts_i.walk_done) state_d = rrts_pkg::S_FIN;
      rrts_pkg::S_FIN: state_d = rrts_pkg::S_IDLE;
      default: state_d = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      rrts_pkg::S_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = start_i;
      end
      rrts_pkg::S_EXEC: cmd_o.exec = 1'b1;
      rrts_pkg::S_WALL: cmd_o.wall_step = 1'b1;
      rrts_pkg::S_UNLINK: cmd_o.unlink_step = 1'b1;
      rrts_pkg::S_FIN: cmd_o.finish = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  a_fin_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rrts_pkg::S_FIN |-> $past(state_q) != rrts_pkg::S_IDLE)
    else $error("finish without work");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("several commands at once");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == rrts_pkg::S_EXEC) else $error("load lost");
endmodule

// ===== rtl/core/rrts_dp.sv =====
// Datapath of the thread scheduler: thread tables, queues and result register.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rrts_pkg::req_t req_i,
  input  rrts_pkg::cmd_t cmd_i,
  output rrts_pkg::sts_t sts_o,
  output rrts_pkg::rsp_t rsp_o,
  output logic           done_o
);
  localparam int PW = rrts_pkg::PtrW;
  localparam int TW = rrts_pkg::TidW;
  localparam int MT = rrts_pkg::MaxThreads;
  localparam int NQ = rrts_pkg::NumQueues;

  rrts_pkg::tstate_e     tst_q [MT];
  logic [PW-1:0]         lnk_q [MT];
  logic [rrts_pkg::QW:0] wq_q  [MT];
  logic [rrts_pkg::NumSignals-1:0] pend_q [MT];
  logic [PW-1:0]         whead_q [NQ];
  logic [PW-1:0]         rhead_q, rtail_q, cur_q, nid_q, before_q, ptr_q;
  rrts_pkg::req_t        req_q;
  logic [1:0]            status_q;
  logic [TW-1:0]         created_q;
  logic [PW-1:0]         cnt_q;
  rrts_pkg::rsp_t        rsp_q;
  logic                  done_q;

  logic [2:0]    fn;
  logic [rrts_pkg::QW-1:0] qi;
  logic          qbad;
  logic [TW-1:0] tgt;
  logic          sigbad;
  logic [TW-1:0] pt;
  logic          ptr_nil;

  assign fn = req_q.func;
  assign qi = rrts_pkg::QW'(req_q.queue_id);
  assign qbad = {1'b0, req_q.queue_id} >= 4'(NQ);
  assign tgt = TW'(req_q.target_thread);
  assign sigbad = ({1'b0, req_q.target_thread} >= 6'(MT)) || (req_q.signal_number == 5'd0)
      || ({1'b0, req_q.signal_number} >= 6'(rrts_pkg::NumSignals))
      || (tst_q[tgt] == rrts_pkg::ST_DEAD);
  assign pt = ptr_q[TW-1:0];
  assign ptr_nil = ptr_q[PW-1];

  always_comb begin
    sts_o.need_wall = (fn == rrts_pkg::FN_WAKEALL) && !qbad;
    sts_o.need_unlink = (fn == rrts_pkg::FN_SIGNAL) && !sigbad
        && tst_q[tgt] == rrts_pkg::ST_BLOCK && whead_q[wq_q[tgt][rrts_pkg::QW-1:0]] != {1'b0, tgt};
    sts_o.walk_done = ptr_nil || cnt_q == PW'(MT)
        || (cmd_i.unlink_step && lnk_q[pt] == {1'b0, tgt});
  end

  // State update for load, execute, list walk and finish; ready-tail pushes are inlined below.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MT; i++) begin
        tst_q[i] <= (i == 0) ? rrts_pkg::ST_RUN : rrts_pkg::ST_DEAD;
        lnk_q[i] <= rrts_pkg::Nil;
        wq_q[i] <= (rrts_pkg::QW+1)'(NQ);
        pend_q[i] <= '0;
      end
      for (int j = 0; j < NQ; j++) whead_q[j] <= rrts_pkg::Nil;
      rhead_q <= rrts_pkg::Nil;
      rtail_q <= rrts_pkg::Nil;
      cur_q <= '0;
      nid_q <= PW'(1);
      done_q <= 1'b0;
      rsp_q <= '0;
      req_q <= '0;
      status_q <= '0;
      created_q <= '0;
      before_q <= '0;
      ptr_q <= rrts_pkg::Nil;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load) begin
        req_q <= req_i;
        before_q <= cur_q;
        status_q <= rrts_pkg::STS_OK;
        created_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.exec) begin
        case (fn)
          rrts_pkg::FN_YIELD: begin
            if (cur_q[PW-1]) status_q <= rrts_pkg::STS_STALL;
            else if (!rhead_q[PW-1]) begin
              // Pop head, push current to tail.
              tst_q[rhead_q[TW-1:0]] <= rrts_pkg::ST_RUN;
              cur_q <= rhead_q;
              lnk_q[cur_q[TW-1:0]] <= rrts_pkg::Nil;
              tst_q[cur_q[TW-1:0]] <= rrts_pkg::ST_READY;
              wq_q[cur_q[TW-1:0]] <= (rrts_pkg::QW+1)'(NQ);
              lnk_q[rhead_q[TW-1:0]] <= rrts_pkg::Nil;
              if (lnk_q[rhead_q[TW-1:0]][PW-1]) begin
                rhead_q <= cur_q;
              end else begin
                rhead_q <= lnk_q[rhead_q[TW-1:0]];
                lnk_q[rtail_q[TW-1:0]] <= cur_q;
              end
              rtail_q <= cur_q;
            end
          end
          rrts_pkg::FN_CREATE: begin
            if (nid_q >= PW'(MT)) status_q <= rrts_pkg::STS_EXHAUST;
            else begin
              nid_q <= nid_q + PW'(1);
              pend_q[nid_q[TW-1:0]] <= '0;
              created_q <= nid_q[TW-1:0];
              lnk_q[nid_q[TW-1:0]] <= rrts_pkg::Nil;
              tst_q[nid_q[TW-1:0]] <= rrts_pkg::ST_READY;
              wq_q[nid_q[TW-1:0]] <= (rrts_pkg::QW+1)'(NQ);
              if (!rtail_q[PW-1]) lnk_q[rtail_q[TW-1:0]] <= nid_q;
              else rhead_q <= nid_q;
              rtail_q <= nid_q;
            end
          end
          rrts_pkg::FN_SLEEP, rrts_pkg::FN_EXIT: begin
            if (fn == rrts_pkg::FN_SLEEP && qbad) status_q <= rrts_pkg::STS_BADARG;
            else if (cur_q[PW-1]) status_q <= rrts_pkg::STS_STALL;
            else begin
              if (fn == rrts_pkg::FN_SLEEP) begin
                tst_q[cur_q[TW-1:0]] <= rrts_pkg::ST_BLOCK;
                wq_q[cur_q[TW-1:0]] <= {1'b0, qi};
                lnk_q[cur_q[TW-1:0]] <= whead_q[qi];
                whead_q[qi] <= cur_q;
              end else begin
                tst_q[cur_q[TW-1:0]] <= rrts_pkg::ST_DEAD;
                lnk_q[cur_q[TW-1:0]] <= rrts_pkg::Nil;
                wq_q[cur_q[TW-1:0]] <= (rrts_pkg::QW+1)'(NQ);
              end
              cur_q <= rrts_pkg::Nil;
              if (rhead_q[PW-1]) status_q <= rrts_pkg::STS_STALL;
            end
          end
          rrts_pkg::FN_WAKE1: begin
            if (qbad) status_q <= rrts_pkg::STS_BADARG;
            else if (!whead_q[qi][PW-1]) begin
              whead_q[qi] <= lnk_q[whead_q[qi][TW-1:0]];
              lnk_q[whead_q[qi][TW-1:0]] <= rrts_pkg::Nil;
              tst_q[whead_q[qi][TW-1:0]] <= rrts_pkg::ST_READY;
              wq_q[whead_q[qi][TW-1:0]] <= (rrts_pkg::QW+1)'(NQ);
              if (!rtail_q[PW-1]) lnk_q[rtail_q[TW-1:0]] <= whead_q[qi];
              else rhead_q <= whead_q[qi];
              rtail_q <= whead_q[qi];
            end
          end
          rrts_pkg::FN_WAKEALL: begin
            if (qbad) status_q <= rrts_pkg::STS_BADARG;
            else begin
              ptr_q <= whead_q[qi];
              whead_q[qi] <= rrts_pkg::Nil;
            end
          end
          rrts_pkg::FN_SIGNAL: begin
            if (sigbad) status_q <= rrts_pkg::STS_BADARG;
            else begin
              pend_q[tgt][rrts_pkg::SigW'(req_q.signal_number)] <= 1'b1;
              if (tst_q[tgt] == rrts_pkg::ST_BLOCK) begin
                if (whead_q[wq_q[tgt][rrts_pkg::QW-1:0]] == {1'b0, tgt}) begin
                  whead_q[wq_q[tgt][rrts_pkg::QW-1:0]] <= lnk_q[tgt];
                  // Push target onto ready tail.
                  lnk_q[tgt] <= rrts_pkg::Nil;
                  tst_q[tgt] <= rrts_pkg::ST_READY;
                  wq_q[tgt] <= (rrts_pkg::QW+1)'(NQ);
                  if (!rtail_q[PW-1]) lnk_q[rtail_q[TW-1:0]] <= {1'b0, tgt};
                  else rhead_q <= {1'b0, tgt};
                  rtail_q <= {1'b0, tgt};
                end else begin
                  ptr_q <= whead_q[wq_q[tgt][rrts_pkg::QW-1:0]];
                end
              end
            end
          end
          default: status_q <= rrts_pkg::STS_OK;
        endcase
      end
      if (cmd_i.wall_step && !ptr_nil && cnt_q != PW'(MT)) begin
        // Move one waiter to the ready tail, follow its link.
        cnt_q <= cnt_q + PW'(1);
        ptr_q <= lnk_q[pt];
        lnk_q[pt] <= rrts_pkg::Nil;
        tst_q[pt] <= rrts_pkg::ST_READY;
        wq_q[pt] <= (rrts_pkg::QW+1)'(NQ);
        if (!rtail_q[PW-1]) lnk_q[rtail_q[TW-1:0]] <= ptr_q;
        else rhead_q <= ptr_q;
        rtail_q <= ptr_q;
      end
      if (cmd_i.unlink_step) begin
        if (!ptr_nil && cnt_q != PW'(MT) && lnk_q[pt] == {1'b0, tgt}) begin
          lnk_q[pt] <= lnk_q[tgt];
        end else begin
          cnt_q <= cnt_q + PW'(1);
          ptr_q <= lnk_q[pt];
        end
        if (sts_o.walk_done) begin
          lnk_q[tgt] <= rrts_pkg::Nil;
          tst_q[tgt] <= rrts_pkg::ST_READY;
          wq_q[tgt] <= (rrts_pkg::QW+1)'(NQ);
          if (!rtail_q[PW-1] && rtail_q != {1'b0, pt}) lnk_q[rtail_q[TW-1:0]] <= {1'b0, tgt};
          else if (rtail_q[PW-1]) rhead_q <= {1'b0, tgt};
          rtail_q <= {1'b0, tgt};
        end
      end
      if (cmd_i.finish) begin
        done_q <= 1'b1;
        if (cur_q[PW-1] && !rhead_q[PW-1]) begin
          cur_q <= rhead_q;
          tst_q[rhead_q[TW-1:0]] <= rrts_pkg::ST_RUN;
          rhead_q <= lnk_q[rhead_q[TW-1:0]];
          if (lnk_q[rhead_q[TW-1:0]][PW-1]) rtail_q <= rrts_pkg::Nil;
          lnk_q[rhead_q[TW-1:0]] <= rrts_pkg::Nil;
          rsp_q.running_thread <= rhead_q[TW-1:0];
          rsp_q.running_valid <= 1'b1;
          rsp_q.switched <= rhead_q != before_q;
        end else begin
          rsp_q.running_thread <= cur_q[PW-1] ? 5'd0 : cur_q[TW-1:0];
          rsp_q.running_valid <= !cur_q[PW-1];
          rsp_q.switched <= cur_q != before_q;
        end
        rsp_q.created_thread <= created_q;
        rsp_q.status <= status_q;
      end
    end
  end

  assign rsp_o = rsp_q;
  assign done_o = done_q;

  a_tail_nil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rhead_q[PW-1] |-> rtail_q[PW-1]) else $error("ready tail without head");
  a_cur_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !cur_q[PW-1] |-> tst_q[cur_q[TW-1:0]] == rrts_pkg::ST_RUN)
    else $error("current thread not running");
  a_valid_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_q.running_valid == !cur_q[PW-1]) else $error("valid mismatch");
endmodule

// ===== tb/round_robin_thread_scheduler_test.sv =====
// Self-checking testbench for the round-robin thread scheduler.
// Depends on rrts_pkg and round_robin_thread_scheduler; predicts every result itself.
`timescale 1ns / 1ps
module round_robin_thread_scheduler_test;
  localparam int NilId = rrts_pkg::MaxThreads;
  localparam int NoQueue = rrts_pkg::NumQueues;
  localparam int CycleLimit = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  rrts_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  rrts_pkg::rsp_t rsp_o;

  round_robin_thread_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the scheduler tables, kept in step with accepted items.
  rrts_pkg::tstate_e sched_state[rrts_pkg::MaxThreads];
  int sched_link[rrts_pkg::MaxThreads];
  int sched_waitq[rrts_pkg::MaxThreads];
  logic [rrts_pkg::NumSignals-1:0] sched_pending[rrts_pkg::MaxThreads];
  int wait_top[rrts_pkg::NumQueues];
  int ready_first, ready_last, running_id, id_counter;

  rrts_pkg::req_t event_queue[$];
  rrts_pkg::rsp_t expected_rsp[$];
  int error_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  bit hold_sender = 1'b0;

  function automatic void clear_tables();
    for (int i = 0; i < rrts_pkg::MaxThreads; i++) begin
      sched_state[i] = rrts_pkg::ST_DEAD;
      sched_link[i] = NilId;
      sched_waitq[i] = NoQueue;
      sched_pending[i] = '0;
    end
    for (int i = 0; i < rrts_pkg::NumQueues; i++) wait_top[i] = NilId;
    ready_first = NilId;
    ready_last = NilId;
    sched_state[0] = rrts_pkg::ST_RUN;
    running_id = 0;
    id_counter = 1;
  endfunction

  function automatic void make_ready(int t);
    sched_link[t] = NilId;
    sched_state[t] = rrts_pkg::ST_READY;
    sched_waitq[t] = NoQueue;
    if (ready_last < NilId) sched_link[ready_last] = t;
    else ready_first = t;
    ready_last = t;
  endfunction

  function automatic int take_ready();
    int t;
    t = ready_first;
    if (t >= NilId) return NilId;
    ready_first = sched_link[t];
    if (ready_first >= NilId) begin
      ready_first = NilId;
      ready_last = NilId;
    end
    sched_link[t] = NilId;
    return t;
  endfunction

  // Drops the running thread without requeueing it and dispatches the next one.
  function automatic rrts_pkg::status_e switch_away();
    running_id = take_ready();
    if (running_id >= NilId) return rrts_pkg::STS_STALL;
    sched_state[running_id] = rrts_pkg::ST_RUN;
    return rrts_pkg::STS_OK;
  endfunction

  function automatic rrts_pkg::rsp_t schedule_event(rrts_pkg::req_t r);
    rrts_pkg::rsp_t res;
    int prev, t, n, p, w;
    rrts_pkg::status_e sts;
    int created;
    prev = running_id;
    sts = rrts_pkg::STS_OK;
    created = 0;
    case (rrts_pkg::func_e'(r.func))
      rrts_pkg::FN_YIELD: begin
        if (running_id >= NilId) sts = rrts_pkg::STS_STALL;
        else if (ready_first < NilId) begin
          n = take_ready();
          make_ready(running_id);
          sched_state[n] = rrts_pkg::ST_RUN;
          running_id = n;
        end
      end
      rrts_pkg::FN_CREATE: begin
        if (id_counter >= rrts_pkg::MaxThreads) sts = rrts_pkg::STS_EXHAUST;
        else begin
          t = id_counter;
          id_counter++;
          sched_pending[t] = '0;
          make_ready(t);
          created = t;
        end
      end
      rrts_pkg::FN_SLEEP: begin
        if (running_id >= NilId) sts = rrts_pkg::STS_STALL;
        else begin
          t = running_id;
          sched_state[t] = rrts_pkg::ST_BLOCK;
          sched_waitq[t] = r.queue_id;
          sched_link[t] = wait_top[r.queue_id];
          wait_top[r.queue_id] = t;
          sts = switch_away();
        end
      end
      rrts_pkg::FN_WAKE1: begin
        t = wait_top[r.queue_id];
        if (t < NilId) begin
          wait_top[r.queue_id] = sched_link[t];
          make_ready(t);
        end
      end
      rrts_pkg::FN_WAKEALL: begin
        t = wait_top[r.queue_id];
        wait_top[r.queue_id] = NilId;
        for (int k = 0; k < rrts_pkg::MaxThreads && t < NilId; k++) begin
          n = sched_link[t];
          make_ready(t);
          t = n;
        end
      end
      rrts_pkg::FN_SIGNAL: begin
        t = r.target_thread;
        if (r.signal_number == 0 || sched_state[t] == rrts_pkg::ST_DEAD)
          sts = rrts_pkg::STS_BADARG;
        else begin
          sched_pending[t][r.signal_number] = 1'b1;
          if (sched_state[t] == rrts_pkg::ST_BLOCK && sched_waitq[t] < NoQueue) begin
            w = sched_waitq[t];
            if (wait_top[w] == t) wait_top[w] = sched_link[t];
            else begin
              p = wait_top[w];
              for (int k = 0; k < rrts_pkg::MaxThreads && p < NilId; k++) begin
                if (sched_link[p] == t) begin
                  sched_link[p] = sched_link[t];
                  break;
                end
                p = sched_link[p];
              end
            end
            make_ready(t);
          end
        end
      end
      rrts_pkg::FN_EXIT: begin
        if (running_id >= NilId) sts = rrts_pkg::STS_STALL;
        else begin
          sched_state[running_id] = rrts_pkg::ST_DEAD;
          sched_link[running_id] = NilId;
          sched_waitq[running_id] = NoQueue;
          sts = switch_away();
        end
      end
      default: ;
    endcase
    // A stalled scheduler dispatches the first thread made ready at once.
    if (running_id >= NilId && ready_first < NilId) begin
      n = take_ready();
      sched_state[n] = rrts_pkg::ST_RUN;
      running_id = n;
    end
    res.running_thread = (running_id < NilId) ? running_id[4:0] : 5'd0;
    res.running_valid = running_id < NilId;
    res.switched = running_id != prev;
    res.created_thread = created[4:0];
    res.status = sts;
    return res;
  endfunction

  function automatic rrts_pkg::req_t make_event(rrts_pkg::func_e f, int q, int tgt, int sig);
    rrts_pkg::req_t r;
    r.func = f;
    r.queue_id = q[2:0];
    r.target_thread = tgt[4:0];
    r.signal_number = sig[4:0];
    return r;
  endfunction

  // Random events weighted toward a live mix of sleeps, wakes and signals.
  function automatic rrts_pkg::req_t random_event();
    int pick;
    rrts_pkg::func_e f;
    pick = $urandom_range(99);
    if (pick < 16) f = rrts_pkg::FN_YIELD;
    else if (pick < 26) f = rrts_pkg::FN_CREATE;
    else if (pick < 44) f = rrts_pkg::FN_SLEEP;
    else if (pick < 58) f = rrts_pkg::FN_WAKE1;
    else if (pick < 66) f = rrts_pkg::FN_WAKEALL;
    else if (pick < 86) f = rrts_pkg::FN_SIGNAL;
    else if (pick < 95) f = rrts_pkg::FN_EXIT;
    else f = rrts_pkg::FN_NOP;
    return make_event(f, $urandom_range(rrts_pkg::NumQueues - 1),
                      $urandom_range(rrts_pkg::MaxThreads - 1),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(rrts_pkg::NumSignals - 1));
  endfunction

  // Driver: presents queued items, idling at random while the idle rate says so.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsp.push_back(schedule_event(req_i));
      end
      if (start && busy) begin
        // Item still waiting to be taken; keep it on the port.
      end else if (event_queue.size() != 0 && !hold_sender &&
                   $urandom_range(99) >= idle_pct) begin
        req_i <= event_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    rrts_pkg::rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no item outstanding: %p", rsp_o);
        error_count++;
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (rsp_o.running_thread !== exp_rsp.running_thread) begin
          $error("running_thread expected %0d got %0d", exp_rsp.running_thread,
                 rsp_o.running_thread);
          error_count++;
        end
        if (rsp_o.running_valid !== exp_rsp.running_valid) begin
          $error("running_valid expected %0d got %0d", exp_rsp.running_valid,
                 rsp_o.running_valid);
          error_count++;
        end
        if (rsp_o.switched !== exp_rsp.switched) begin
          $error("switched expected %0d got %0d", exp_rsp.switched, rsp_o.switched);
          error_count++;
        end
        if (rsp_o.created_thread !== exp_rsp.created_thread) begin
          $error("created_thread expected %0d got %0d", exp_rsp.created_thread,
                 rsp_o.created_thread);
          error_count++;
        end
        if (rsp_o.status !== exp_rsp.status) begin
          $error("status expected %0d got %0d", exp_rsp.status, rsp_o.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[round_robin_thread_scheduler] ERROR");
      $finish;
    end
  end

  task automatic drain_all();
    while (event_queue.size() != 0 || start || busy || expected_rsp.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    clear_tables();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: stalls, bad arguments and list edge cases.
    event_queue.push_back(make_event(rrts_pkg::FN_NOP, 7, 31, 31));
    event_queue.push_back(make_event(rrts_pkg::FN_YIELD, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SIGNAL, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SIGNAL, 0, 31, 5));
    event_queue.push_back(make_event(rrts_pkg::FN_SIGNAL, 0, 0, 31));
    event_queue.push_back(make_event(rrts_pkg::FN_WAKE1, 3, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SLEEP, 7, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_YIELD, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SLEEP, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_CREATE, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_CREATE, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_CREATE, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SLEEP, 7, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SLEEP, 7, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SIGNAL, 0, 1, 1));
    event_queue.push_back(make_event(rrts_pkg::FN_YIELD, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_SLEEP, 7, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_EXIT, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_EXIT, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_WAKEALL, 7, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_WAKEALL, 0, 0, 0));
    event_queue.push_back(make_event(rrts_pkg::FN_EXIT, 0, 0, 0));
    drain_all();

    // Random phases with differing sender idle rates.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 74 : (phase == 2) ? 12 : 0;
      for (int i = 0; i < 420; i++) event_queue.push_back(random_event());
      if (phase == 2) begin
        // Run the identifier counter out so exhaustion shows up late too.
        for (int i = 0; i < 32; i++)
          event_queue.push_back(make_event(rrts_pkg::FN_CREATE, 0, 0, 0));
      end
      while (event_queue.size() > 200) @(posedge clk_i);
      // Hold the sender until every outstanding result is back.
      hold_sender = 1'b1;
      while (start || busy || expected_rsp.size() != 0) @(posedge clk_i);
      hold_sender = 1'b0;
      drain_all();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_rsp.size() == 0)
      $display("[round_robin_thread_scheduler] OK");
    else
      $display("[round_robin_thread_scheduler] ERROR");
    $finish;
  end
endmodule
